FILE: rtl/core/qsl_pkg.sv
// Shared types for the quicksort batch sorter.
`timescale 1ns / 1ps

package qsl_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [14:0] {
        ST_IDLE      = 15'b000000000000001,
        ST_POP       = 15'b000000000000010,
        ST_RANGE     = 15'b000000000000100,
        ST_PIVOT     = 15'b000000000001000,
        ST_CMP       = 15'b000000000010000,
        ST_SWAP1     = 15'b000000000100000,
        ST_SWAP2     = 15'b000000001000000,
        ST_FIN_RD    = 15'b000000010000000,
        ST_FIN1      = 15'b000000100000000,
        ST_FIN2      = 15'b000001000000000,
        ST_PUSH2     = 15'b000010000000000,
        ST_NEXT      = 15'b000100000000000,
        ST_EMIT_RD   = 15'b001000000000000,
        ST_EMIT_LD   = 15'b010000000000000,
        ST_EMIT_WAIT = 15'b100000000000000
    } t_state;

    localparam int VALUE_W = 32;

endpackage

FILE: rtl/core/qsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module qsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read returns the old contents on a same-address write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/core/quicksort_lomuto.sv
// Batch sorter: in-place ascending quicksort with Lomuto partitioning.
// After the last item the sort reads and compares each element of a range against its pivot,
//   swapping it into the k slot as needed, then places the pivot; each result is read, loaded
//   and held until taken. Throughput is set by the single read port of the store.
// One item is loaded per cycle while idle; no item is taken from the last item until the final
//   result of the batch leaves. i_rst_n (synchronous, active low) clears the count, the stack
//   pointer, the overflow flag and the sequencer; the stores need no clearing pass.
`timescale 1ns / 1ps

module quicksort_lomuto #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tlast,   // last_item
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
    output logic        m_axis_tlast,   // last_result
    output logic        m_axis_tuser    // [0] dropped
);

    localparam int IDX_W = $clog2(DEPTH);      // element index
    localparam int CNT_W = $clog2(DEPTH + 1);  // element count, stack pointer
    localparam int ENT_W = 2 * IDX_W;          // stack entry {lo, hi}
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // Control state
    qsl_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_sp, n_sp;
    logic             r_ovf, n_ovf;

    // Partition working registers
    logic [IDX_W-1:0] r_lo, n_lo;
    logic [IDX_W-1:0] r_hi, n_hi;
    logic [IDX_W-1:0] r_k, n_k;       // next slot for a smaller element
    logic [IDX_W-1:0] r_j, n_j;       // scan index, also emit index
    logic [31:0]      r_pivot, n_pivot;
    logic [31:0]      r_aj, n_aj;     // element at j
    logic [31:0]      r_kv, n_kv;     // element at k during a swap
    logic [ENT_W-1:0] r_push2, n_push2;

    // Output register
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_out_data, n_out_data;
    logic             r_out_last, n_out_last;
    logic             r_out_drop, n_out_drop;

    // Element store port
    logic             st_we;
    logic [IDX_W-1:0] st_waddr, st_raddr;
    logic [31:0]      st_wdata, st_rdata;

    // Range stack port
    logic             sk_we;
    logic [IDX_W-1:0] sk_waddr, sk_raddr;
    logic [ENT_W-1:0] sk_wdata, sk_rdata;

    // Helpers
    logic [IDX_W-1:0] j_inc;
    logic [CNT_W-1:0] sp_dec;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] j_ext;
    logic [IDX_W:0]   p_ext, lo_ext, hi_ext;
    logic             left_ok, right_ok, less;
    logic [ENT_W-1:0] left_ent, right_ent;

    qsl_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    qsl_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (sk_we),
        .i_waddr (sk_waddr),
        .i_wdata (sk_wdata),
        .i_raddr (sk_raddr),
        .o_rdata (sk_rdata)
    );

    assign s_axis_tready = (r_state == qsl_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_drop;

    assign j_inc   = r_j + 1'b1;
    assign sp_dec  = r_sp - 1'b1;
    assign cnt_inc = r_count + 1'b1;
    assign j_ext   = CNT_W'(r_j);

    // The element comparator: signed element against the pivot.
    assign less = $signed(st_rdata) < $signed(r_pivot);

    // Split decision once the pivot sits at index k.
    assign p_ext     = {1'b0, r_k};
    assign lo_ext    = {1'b0, r_lo};
    assign hi_ext    = {1'b0, r_hi};
    assign left_ok   = p_ext > (lo_ext + 1'b1);
    assign right_ok  = hi_ext > (p_ext + 1'b1);
    assign left_ent  = {r_lo, r_k - 1'b1};
    assign right_ent = {r_k + 1'b1, r_hi};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sp        = r_sp;
        n_ovf       = r_ovf;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_k         = r_k;
        n_j         = r_j;
        n_pivot     = r_pivot;
        n_aj        = r_aj;
        n_kv        = r_kv;
        n_push2     = r_push2;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_drop  = r_out_drop;
        st_we       = 1'b0;
        st_waddr    = r_k;
        st_wdata    = r_aj;
        st_raddr    = r_j;
        sk_we       = 1'b0;
        sk_waddr    = r_sp[IDX_W-1:0];
        sk_wdata    = r_push2;
        sk_raddr    = sp_dec[IDX_W-1:0];

        case (r_state)
            qsl_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    // Append while there is room, else drop and flag the batch.
                    if (r_count < DEPTH_C) begin
                        st_we    = 1'b1;
                        st_waddr = r_count[IDX_W-1:0];
                        st_wdata = s_axis_tdata;
                        n_count  = cnt_inc;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        if (n_count < CNT_W'(2)) begin
                            n_j     = '0;
                            n_state = qsl_pkg::ST_EMIT_RD;
                        end else begin
                            // Seed the stack with the whole store.
                            sk_we    = 1'b1;
                            sk_waddr = '0;
                            sk_wdata = {{IDX_W{1'b0}}, IDX_W'(n_count - 1'b1)};
                            n_sp     = CNT_W'(1);
                            n_state  = qsl_pkg::ST_POP;
                        end
                    end
                end
            end

            qsl_pkg::ST_POP: begin
                sk_raddr = sp_dec[IDX_W-1:0];
                n_sp     = sp_dec;
                n_state  = qsl_pkg::ST_RANGE;
            end

            qsl_pkg::ST_RANGE: begin
                if (sk_rdata[ENT_W-1:IDX_W] >= sk_rdata[IDX_W-1:0]) begin
                    n_state = qsl_pkg::ST_NEXT;
                end else begin
                    n_lo     = sk_rdata[ENT_W-1:IDX_W];
                    n_hi     = sk_rdata[IDX_W-1:0];
                    n_k      = sk_rdata[ENT_W-1:IDX_W];
                    n_j      = sk_rdata[ENT_W-1:IDX_W];
                    st_raddr = sk_rdata[IDX_W-1:0];
                    n_state  = qsl_pkg::ST_PIVOT;
                end
            end

            qsl_pkg::ST_PIVOT: begin
                n_pivot  = st_rdata;
                st_raddr = r_j;
                n_state  = qsl_pkg::ST_CMP;
            end

            qsl_pkg::ST_CMP: begin
                n_aj = st_rdata;
                if (less && (r_k != r_j)) begin
                    st_raddr = r_k;
                    n_state  = qsl_pkg::ST_SWAP1;
                end else begin
                    if (less) begin
                        n_k = r_k + 1'b1;
                    end
                    if (j_inc == r_hi) begin
                        n_state = qsl_pkg::ST_FIN_RD;
                    end else begin
                        n_j      = j_inc;
                        st_raddr = j_inc;
                    end
                end
            end

            qsl_pkg::ST_SWAP1: begin
                n_kv     = st_rdata;
                st_we    = 1'b1;
                st_waddr = r_k;
                st_wdata = r_aj;
                n_state  = qsl_pkg::ST_SWAP2;
            end

            qsl_pkg::ST_SWAP2: begin
                st_we    = 1'b1;
                st_waddr = r_j;
                st_wdata = r_kv;
                n_k      = r_k + 1'b1;
                if (j_inc == r_hi) begin
                    n_state = qsl_pkg::ST_FIN_RD;
                end else begin
                    n_j      = j_inc;
                    st_raddr = j_inc;
                    n_state  = qsl_pkg::ST_CMP;
                end
            end

            qsl_pkg::ST_FIN_RD: begin
                st_raddr = r_k;
                n_state  = qsl_pkg::ST_FIN1;
            end

            qsl_pkg::ST_FIN1: begin
                st_we    = 1'b1;
                st_waddr = r_hi;
                st_wdata = st_rdata;
                n_state  = qsl_pkg::ST_FIN2;
            end

            qsl_pkg::ST_FIN2: begin
                // Place the pivot, then push the larger side first.
                st_we    = 1'b1;
                st_waddr = r_k;
                st_wdata = r_pivot;
                n_state  = qsl_pkg::ST_NEXT;
                if (left_ok || right_ok) begin
                    if (left_ok && right_ok) begin
                        if ((r_k - r_lo) > (r_hi - r_k)) begin
                            sk_wdata = left_ent;
                            n_push2  = right_ent;
                        end else begin
                            sk_wdata = right_ent;
                            n_push2  = left_ent;
                        end
                        n_state = qsl_pkg::ST_PUSH2;
                    end else if (left_ok) begin
                        sk_wdata = left_ent;
                    end else begin
                        sk_wdata = right_ent;
                    end
                    if (r_sp < DEPTH_C) begin
                        sk_we    = 1'b1;
                        sk_waddr = r_sp[IDX_W-1:0];
                        n_sp     = r_sp + 1'b1;
                    end
                end
            end

            qsl_pkg::ST_PUSH2: begin
                if (r_sp < DEPTH_C) begin
                    sk_we    = 1'b1;
                    sk_waddr = r_sp[IDX_W-1:0];
                    sk_wdata = r_push2;
                    n_sp     = r_sp + 1'b1;
                end
                n_state = qsl_pkg::ST_NEXT;
            end

            qsl_pkg::ST_NEXT: begin
                if (r_sp != '0) begin
                    n_state = qsl_pkg::ST_POP;
                end else begin
                    n_j     = '0;
                    n_state = qsl_pkg::ST_EMIT_RD;
                end
            end

            qsl_pkg::ST_EMIT_RD: begin
                st_raddr = r_j;
                n_state  = qsl_pkg::ST_EMIT_LD;
            end

            qsl_pkg::ST_EMIT_LD: begin
                n_out_valid = 1'b1;
                n_out_data  = st_rdata;
                n_out_last  = ((j_ext + 1'b1) == r_count);
                n_out_drop  = r_ovf;
                n_state     = qsl_pkg::ST_EMIT_WAIT;
            end

            qsl_pkg::ST_EMIT_WAIT: begin
                // Hold the result until taken; the final one empties the store.
                if (m_axis_tready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_sp    = '0;
                        n_state = qsl_pkg::ST_IDLE;
                    end else begin
                        n_j     = j_inc;
                        n_state = qsl_pkg::ST_EMIT_RD;
                    end
                end
            end

            default: begin
                n_state = qsl_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qsl_pkg::ST_IDLE;
            r_count     <= '0;
            r_sp        <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sp        <= n_sp;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_k        <= n_k;
        r_j        <= n_j;
        r_pivot    <= n_pivot;
        r_aj       <= n_aj;
        r_kv       <= n_kv;
        r_push2    <= n_push2;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_drop <= n_out_drop;
    end

    // A result is only offered from the emit wait state.
    a_valid_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == qsl_pkg::ST_EMIT_WAIT))
        else $error("result valid outside emit");

    // Count and stack pointer stay within the store.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= DEPTH_C) && (r_sp <= DEPTH_C))
        else $error("count or stack pointer beyond depth");

    // During the scan k trails j and j stays below the pivot index.
    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qsl_pkg::ST_CMP) |-> ((r_k <= r_j) && (r_j < r_hi)))
        else $error("partition indexes out of order");

    // Delivering the final result empties the store and returns to idle.
    a_batch_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast)
            |=> ((r_count == '0) && !r_ovf && (r_state == qsl_pkg::ST_IDLE)))
        else $error("store not emptied after batch");

endmodule

FILE: test/tb_quicksort_lomuto.sv
// Testbench for the quicksort batch sorter: directed and random batches checked against an in-bench sort.
`timescale 1ns / 1ps

module tb_quicksort_lomuto;

    localparam int VALUE_W = qsl_pkg::VALUE_W;
    localparam int DEPTH   = 64;

    // One expected result item of a sorted batch
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               dropped;
    } t_sorted_result;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [VALUE_W-1:0] s_axis_tdata  = '0;   // [31:0] value
    logic               s_axis_tlast  = 1'b0; // last_item
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [VALUE_W-1:0] m_axis_tdata;         // [31:0] sorted_value
    logic               m_axis_tlast;         // last_result
    logic               m_axis_tuser;         // [0] dropped

    // Batch being collected by the predictor, and results still owed by the block
    logic [VALUE_W-1:0] batch_store [DEPTH];
    int                 batch_count    = 0;
    logic               batch_overflow = 1'b0;
    t_sorted_result     pending_results[$];

    int fail_count   = 0;
    int random_items = 0;
    bit src_idle_en  = 1'b1;
    bit snk_idle_en  = 1'b1;

    quicksort_lomuto #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Append an accepted item to the batch; on the last item sort it ascending
    // (signed) and queue one expected result per held element.
    task automatic accept_into_batch(input logic [VALUE_W-1:0] value, input logic last);
        int                 i;
        int                 j;
        logic [VALUE_W-1:0] key;
        t_sorted_result     r;
        if (batch_count < DEPTH) begin
            batch_store[batch_count] = value;
            batch_count++;
        end else begin
            batch_overflow = 1'b1;
        end
        if (last) begin
            for (i = 1; i < batch_count; i++) begin
                key = batch_store[i];
                j   = i - 1;
                while (j >= 0 && $signed(batch_store[j]) > $signed(key)) begin
                    batch_store[j + 1] = batch_store[j];
                    j--;
                end
                batch_store[j + 1] = key;
            end
            for (i = 0; i < batch_count; i++) begin
                r.value   = batch_store[i];
                r.last    = (i == batch_count - 1);
                r.dropped = batch_overflow;
                pending_results.push_back(r);
            end
            batch_count    = 0;
            batch_overflow = 1'b0;
        end
    endtask

    // Offer one item; called and returns at a falling edge. Valid stays high
    // across back-to-back items so it is never dropped and raised in one step.
    task automatic send_item(input logic [VALUE_W-1:0] value, input logic last);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        accept_into_batch(value, last);
        @(negedge i_clk);
    endtask

    // Mix of extremes, near-extremes, small values that collide, and full-range noise.
    function automatic logic [VALUE_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000 + 32'($urandom_range(0, 3));
            1:       return 32'h7fff_ffff - 32'($urandom_range(0, 3));
            2, 3:    return 32'($urandom_range(0, 8)) - 32'd4;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_batch(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            send_item(draw_value(), i == n - 1);
        end
    endtask

    // Single-element batches at both signed extremes and at zero
    task automatic test_single_items();
        send_item(32'h8000_0000, 1'b1);
        send_item(32'h7fff_ffff, 1'b1);
        send_item(32'h0000_0000, 1'b1);
    endtask

    // Both signs, extremes and a run of equal values in one batch
    task automatic test_mixed_signs();
        send_item(32'h7fff_ffff, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hffff_ffff, 1'b0);
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h0000_0005, 1'b0);
        send_item(32'h0000_0005, 1'b0);
        send_item(32'h0000_0005, 1'b1);
    endtask

    // Already ordered and reverse ordered input, the worst cases for a last-element pivot
    task automatic test_presorted();
        int i;
        for (i = 0; i < 5; i++) send_item(32'(i) - 32'd2, i == 4);
        for (i = 0; i < 5; i++) send_item(32'd2 - 32'(i), i == 4);
    endtask

    // Exactly full store, then a batch past full whose last item is itself discarded
    task automatic test_full_store();
        send_random_batch(DEPTH);
        send_random_batch(DEPTH + 3);
    endtask

    // Mostly short batches with random content; a few large and overflowing ones
    task automatic test_random_batches();
        int n;
        while (random_items < 55) begin
            src_idle_en = ($urandom_range(0, 3) != 0);
            snk_idle_en = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 19))
                0:       n = $urandom_range(DEPTH - 2, DEPTH + 4);
                1, 2:    n = $urandom_range(16, 40);
                default: n = $urandom_range(1, 10);
            endcase
            send_random_batch(n);
            random_items += n;
        end
    endtask

    // Result side: random stall per item, then check against the oldest expectation
    initial begin : result_check
        int             stall;
        t_sorted_result exp_r;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = snk_idle_en ? $urandom_range(0, 12) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            if (pending_results.size() == 0) begin
                $error("unexpected result item: sorted_value %0d", $signed(m_axis_tdata));
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_axis_tdata !== exp_r.value) begin
                    $error("sorted_value: expected %0d, actual %0d",
                           $signed(exp_r.value), $signed(m_axis_tdata));
                    fail_count++;
                end
                if (m_axis_tlast !== exp_r.last) begin
                    $error("last_result: expected %0b, actual %0b", exp_r.last, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tuser !== exp_r.dropped) begin
                    $error("dropped: expected %0b, actual %0b", exp_r.dropped, m_axis_tuser);
                    fail_count++;
                end
            end
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        #12_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : main_sequence
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_single_items();
        test_mixed_signs();
        test_presorted();
        test_full_store();
        test_random_batches();

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // Hold a little longer to catch any stray result
        repeat (40) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
